FILE: rtl/core/kprl_pkg.sv
package kprl_pkg;

   localparam int unsigned NowWidth   = 32;
   localparam int unsigned IvalWidth  = 16;
   localparam int unsigned CsrIdxWidth = 2;

   typedef enum logic [2:0] {
      KEY_NONE  = 3'd0,
      KEY_LEFT  = 3'd1,
      KEY_UP    = 3'd2,
      KEY_RIGHT = 3'd3,
      KEY_DOWN  = 3'd4,
      KEY_OK    = 3'd5,
      KEY_BACK  = 3'd6
   } key_event_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_REPEAT     = 2'd1
   } csr_index_type;

   localparam logic [IvalWidth-1:0] LongPressReset = 16'd1000;
   localparam logic [IvalWidth-1:0] RepeatReset    = 16'd200;

   // Captured poll handed to the decide stage.
   typedef struct packed {
      logic                valid;
      key_event_type       button;
      logic [NowWidth-1:0] now;
   } poll_type;

   function automatic key_event_type pick_button(input logic left, input logic up,
                                                 input logic right, input logic down,
                                                 input logic ok);
      key_event_type sel;
      if (left) begin
         sel = KEY_LEFT;
      end else if (up) begin
         sel = KEY_UP;
      end else if (right) begin
         sel = KEY_RIGHT;
      end else if (down) begin
         sel = KEY_DOWN;
      end else if (ok) begin
         sel = KEY_OK;
      end else begin
         sel = KEY_NONE;
      end
      return sel;
   endfunction

endpackage

FILE: rtl/core/kprl_capture.sv
module kprl_capture import kprl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_left_pressed,
   input  logic                req_up_pressed,
   input  logic                req_right_pressed,
   input  logic                req_down_pressed,
   input  logic                req_ok_pressed,
   input  logic [NowWidth-1:0] req_now_ms,
   input  logic                take,
   output poll_type            poll
);

   logic                valid_ff, valid_in;
   key_event_type       button_ff, button_in;
   logic [NowWidth-1:0] now_ff, now_in;

   assign req_stall = valid_ff && !take;

   always_comb begin
      valid_in  = valid_ff;
      button_in = button_ff;
      now_in    = now_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
      if (req_valid && !req_stall) begin
         button_in = pick_button(req_left_pressed, req_up_pressed, req_right_pressed,
                                 req_down_pressed, req_ok_pressed);
         now_in    = req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      button_ff <= button_in;
      now_ff    <= now_in;
   end

   assign poll.valid  = valid_ff;
   assign poll.button = button_ff;
   assign poll.now    = now_ff;

endmodule

FILE: rtl/core/kprl_decide.sv
module kprl_decide import kprl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  poll_type               poll,
   output logic                   take,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [IvalWidth-1:0]   csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_key_event
);

   logic [IvalWidth-1:0] long_press_ff, long_press_in;
   logic [IvalWidth-1:0] repeat_ff, repeat_in;
   key_event_type        held_ff, held_in;
   logic [NowWidth-1:0]  stamp_ff, stamp_in;
   logic                 fired_ff, fired_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   key_event_type        event_ff, event_in, ev;
   logic [NowWidth-1:0]  elapsed;

   assign csr_ready = 1'b1;
   assign take      = poll.valid && (!rsp_valid_ff || !rsp_stall);
   assign elapsed   = poll.now - stamp_ff;

   always_comb begin
      long_press_in = long_press_ff;
      repeat_in     = repeat_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LONG_PRESS: long_press_in = csr_wdata;
            CSR_REPEAT:     repeat_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      ev       = KEY_NONE;
      held_in  = held_ff;
      stamp_in = stamp_ff;
      fired_in = fired_ff;
      if (poll.button == KEY_NONE) begin
         held_in  = KEY_NONE;
         fired_in = 1'b0;
         if (held_ff == KEY_OK && !fired_ff) begin
            ev = KEY_OK;
         end
      end else if (poll.button != held_ff) begin
         held_in  = poll.button;
         stamp_in = poll.now;
         fired_in = 1'b0;
         if (poll.button != KEY_OK) begin
            ev = poll.button;
         end
      end else if (poll.button == KEY_OK) begin
         if (!fired_ff && elapsed >= {{(NowWidth-IvalWidth){1'b0}}, long_press_ff}) begin
            fired_in = 1'b1;
            ev       = KEY_BACK;
         end
      end else if (elapsed >= {{(NowWidth-IvalWidth){1'b0}}, repeat_ff}) begin
         stamp_in = poll.now;
         ev       = poll.button;
      end

      event_in     = event_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         event_in     = ev;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LongPressReset;
         repeat_ff     <= RepeatReset;
         held_ff       <= KEY_NONE;
         stamp_ff      <= '0;
         fired_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         long_press_ff <= long_press_in;
         repeat_ff     <= repeat_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (take) begin
            held_ff  <= held_in;
            stamp_ff <= stamp_in;
            fired_ff <= fired_in;
         end
      end
      event_ff <= event_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_event = event_ff;

   a_fired_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      fired_ff |-> held_ff == KEY_OK)
      else $error("long-press flag set without ok held");

   a_back_sets_fired: assert property (@(posedge clock) disable iff (reset)
      (take && ev == KEY_BACK) |=> fired_ff && rsp_key_event == KEY_BACK)
      else $error("back reported without long-press flag");

   a_arrow_tracks_held: assert property (@(posedge clock) disable iff (reset)
      (take && (ev == KEY_LEFT || ev == KEY_UP || ev == KEY_RIGHT || ev == KEY_DOWN))
      |=> held_ff == $past(ev))
      else $error("arrow event does not match held button");

   a_no_take_while_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !take)
      else $error("result overwritten while stalled");

endmodule

FILE: rtl/core/keypad_repeat_long_press.sv
// Channel  Direction  Handshake                 Payload
// req      in         req_valid / req_stall     five pressed flags, req_now_ms
// rsp      out        rsp_valid / rsp_stall     rsp_key_event
// csr      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// One poll per cycle while req_stall is low; a result is valid once its accepted poll
// has passed the input register, then the decide logic into the result register.
// Synchronous active-high reset restores intervals and clears the held state.
// rsp_stall holds the result; a further poll waits in the input register and
// req_stall rises only when both registers are full.
module keypad_repeat_long_press import kprl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_left_pressed,
   input  logic                   req_up_pressed,
   input  logic                   req_right_pressed,
   input  logic                   req_down_pressed,
   input  logic                   req_ok_pressed,
   input  logic [NowWidth-1:0]    req_now_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_key_event,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [IvalWidth-1:0]   csr_wdata
);

   poll_type poll;
   logic     take;

   kprl_capture u_capture (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_left_pressed  (req_left_pressed),
      .req_up_pressed    (req_up_pressed),
      .req_right_pressed (req_right_pressed),
      .req_down_pressed  (req_down_pressed),
      .req_ok_pressed    (req_ok_pressed),
      .req_now_ms        (req_now_ms),
      .take              (take),
      .poll              (poll)
   );

   kprl_decide u_decide (
      .clock         (clock),
      .reset         (reset),
      .poll          (poll),
      .take          (take),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_key_event (rsp_key_event)
   );

endmodule
